/* rtl/hpd_pkg.sv */
//------------------------------------------------------------------------------
// hpd_pkg
// Shared constants, types and the CORDIC arctangent table for the heading
// controller.
//------------------------------------------------------------------------------
`default_nettype none
package hpd_pkg;

  localparam int CordicSteps = 16;
  localparam int TableLen    = 24;
  localparam int NumSteps    = (CordicSteps < TableLen) ? CordicSteps : TableLen;
  localparam int StepW       = $clog2(NumSteps + 1);

  localparam logic signed [16:0] PiQ13    = 17'sd25736;
  localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;
  localparam logic signed [35:0] HalfPiZ  = 36'sd102944;
  localparam logic [7:0]         PwmFloor = 8'd10;
  localparam int                 PdFrac   = 21;

  localparam logic [1:0] RegKp   = 2'd0;
  localparam logic [1:0] RegKd   = 2'd1;
  localparam logic [1:0] RegBase = 2'd2;
  localparam logic [1:0] RegMax  = 2'd3;

  // Decoded item passed from the front end to the back end.
  typedef struct packed {
    logic               by_angle;
    logic signed [15:0] tdx;
    logic signed [15:0] tdy;
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    logic signed [15:0] hang;
  } item_t;

  localparam int ItemW = $bits(item_t);

  function automatic logic [16:0] atan_entry(input logic [4:0] i);
    logic [16:0] v;
    begin
      unique case (i)
        5'd0:    v = 17'd51472;
        5'd1:    v = 17'd30386;
        5'd2:    v = 17'd16055;
        5'd3:    v = 17'd8150;
        5'd4:    v = 17'd4091;
        5'd5:    v = 17'd2047;
        5'd6:    v = 17'd1024;
        5'd7:    v = 17'd512;
        5'd8:    v = 17'd256;
        5'd9:    v = 17'd128;
        5'd10:   v = 17'd64;
        5'd11:   v = 17'd32;
        5'd12:   v = 17'd16;
        5'd13:   v = 17'd8;
        5'd14:   v = 17'd4;
        5'd15:   v = 17'd2;
        5'd16:   v = 17'd1;
        default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/hpd_fifo.sv */
//------------------------------------------------------------------------------
// hpd_fifo
// Two-entry queue that decouples the input front end from the back end.
//------------------------------------------------------------------------------
`default_nettype none
module hpd_fifo
  import hpd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  wire item_t wr_data,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output item_t      rd_data
);

  item_t      mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_wr) wptr_r <= ~wptr_r;
      if (do_rd) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule
`default_nettype wire

/* rtl/hpd_cordic.sv */
//------------------------------------------------------------------------------
// hpd_cordic
// Iterative CORDIC atan2, one rotation per cycle, result in Q3.13 radians.
//------------------------------------------------------------------------------
`default_nettype none
module hpd_cordic
  import hpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] vx,
  input  wire logic signed [15:0] vy,
  output logic                    done,
  output logic signed [16:0]      angle
);

  // x grows by at most about 1.65 times the magnitude of 2^16 * 2^15.
  logic signed [35:0] xs_r, ys_r, z_r, xs_nxt, ys_nxt, z_nxt;
  logic [StepW-1:0]   step_r;
  logic               busy_r, zero_r;
  logic signed [35:0] dx, dy, zr, q;
  logic signed [35:0] x0, y0;

  assign x0 = {{4{vx[15]}}, vx, 16'd0};
  assign y0 = {{4{vy[15]}}, vy, 16'd0};
  assign dx = ys_r >>> step_r;
  assign dy = xs_r >>> step_r;

  always_comb begin
    if (!ys_r[35]) begin
      xs_nxt = xs_r + dx;
      ys_nxt = ys_r - dy;
      z_nxt  = z_r + 36'(atan_entry(5'(step_r)));
    end else begin
      xs_nxt = xs_r - dx;
      ys_nxt = ys_r + dy;
      z_nxt  = z_r - 36'(atan_entry(5'(step_r)));
    end
  end

  assign zr = (z_r + 36'sd4) >>> 3;
  always_comb begin
    if (zero_r)                         q = 36'sd0;
    else if (zr > 36'(PiQ13))           q = 36'(PiQ13);
    else if (zr < -36'(PiQ13))          q = -36'(PiQ13);
    else                                q = zr;
  end
  assign angle = q[16:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      step_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        zero_r <= (vx == 16'sd0) && (vy == 16'sd0);
        if (vx[15]) begin
          if (!vy[15]) begin
            xs_r <= y0; ys_r <= -x0; z_r <= HalfPiZ;
          end else begin
            xs_r <= -y0; ys_r <= x0; z_r <= -HalfPiZ;
          end
        end else begin
          xs_r <= x0; ys_r <= y0; z_r <= '0;
        end
      end else if (busy_r) begin
        xs_r   <= xs_nxt;
        ys_r   <= ys_nxt;
        z_r    <= z_nxt;
        step_r <= step_r + 1'b1;
        if (step_r == StepW'(NumSteps - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/hpd_back.sv */
//------------------------------------------------------------------------------
// hpd_back
// Sequencer: bearing via the CORDIC, heading via the CORDIC or from the item's
// angle, error wrap, PD term, wheel clamping and the output register.
//------------------------------------------------------------------------------
`default_nettype none
module hpd_back
  import hpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire item_t              item,
  input  wire logic signed [15:0] kp,
  input  wire logic signed [15:0] kd,
  input  wire logic [7:0]         base_pwm,
  input  wire logic [7:0]         max_pwm,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_left_pwm,
  output logic [7:0]              out_right_pwm,
  output logic signed [16:0]      out_heading_error,
  output logic signed [15:0]      out_correction
);

  typedef enum logic [2:0] {
    S_IDLE, S_BEAR, S_HEAD, S_ERR, S_MUL, S_SUM, S_OUT
  } state_t;

  state_t             state_r;
  item_t              it_r;
  logic signed [16:0] bear_r, head_r, err_r, prev_r;
  logic signed [33:0] pk_r, pd_r;
  logic signed [35:0] pdsum_r;
  logic               cs_start, cs_done;
  logic signed [15:0] cs_x, cs_y;
  logic signed [16:0] cs_angle;
  logic signed [17:0] e0, b1, h1, e1, derr;
  logic signed [36:0] base_q, sum_l, sum_r, sum_p, sum_m;
  logic signed [15:0] tl, tr, tc;
  logic signed [36:0] tc_full;

  function automatic logic signed [15:0] trunc_q(input logic signed [36:0] v);
    logic signed [36:0] t;
    begin
      t = v[36] ? -((-v) >>> PdFrac) : (v >>> PdFrac);
      if (t > 37'sd32767) return 16'sh7fff;
      else if (t < -37'sd32768) return 16'sh8000;
      else return t[15:0];
    end
  endfunction

  function automatic logic [7:0] wheel(input logic signed [15:0] v,
                                       input logic [7:0] mx);
    begin
      if (v > $signed({8'd0, mx})) return mx;
      else if (v < $signed({8'd0, PwmFloor})) return PwmFloor;
      else return v[7:0];
    end
  endfunction

  assign item_ready = (state_r == S_IDLE) && !out_valid;
  assign cs_x = (state_r == S_IDLE) ? item.tdx : it_r.hx;
  assign cs_y = (state_r == S_IDLE) ? item.tdy : it_r.hy;
  assign cs_start = ((state_r == S_IDLE) && item_valid && item_ready)
                 || ((state_r == S_BEAR) && cs_done && !it_r.by_angle);

  hpd_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cs_start),
    .vx    (cs_x),
    .vy    (cs_y),
    .done  (cs_done),
    .angle (cs_angle)
  );

  assign e0 = 18'(bear_r) - 18'(head_r);
  assign b1 = bear_r[16] ? 18'(bear_r) + TwoPiQ13 : 18'(bear_r);
  assign h1 = head_r[16] ? 18'(head_r) + TwoPiQ13 : 18'(head_r);
  assign e1 = b1 - h1;
  assign derr = 18'(err_r) - 18'(prev_r);
  assign base_q = 37'($signed({1'b0, base_pwm})) <<< PdFrac;
  assign sum_p = base_q + 37'(pdsum_r);
  assign sum_m = base_q - 37'(pdsum_r);
  assign sum_l = it_r.by_angle ? sum_m : sum_p;
  assign sum_r = it_r.by_angle ? sum_p : sum_m;
  assign tl = trunc_q(sum_l);
  assign tr = trunc_q(sum_r);
  assign tc_full = 37'(pdsum_r);
  assign tc = trunc_q(tc_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      prev_r    <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (item_valid && item_ready) begin
          it_r    <= item;
          state_r <= S_BEAR;
        end
        S_BEAR: if (cs_done) begin
          bear_r <= cs_angle;
          if (it_r.by_angle) begin
            head_r  <= {it_r.hang[15], it_r.hang};
            state_r <= S_ERR;
          end else begin
            state_r <= S_HEAD;
          end
        end
        S_HEAD: if (cs_done) begin
          head_r  <= cs_angle;
          state_r <= S_ERR;
        end
        S_ERR: begin
          if (e0 > 18'(PiQ13) || e0 < -18'(PiQ13)) err_r <= e1[16:0];
          else err_r <= e0[16:0];
          state_r <= S_MUL;
        end
        S_MUL: begin
          pk_r    <= 34'(kp * err_r);
          pd_r    <= 34'(kd * derr);
          state_r <= S_SUM;
        end
        S_SUM: begin
          pdsum_r <= 36'(pk_r) + 36'(pd_r);
          prev_r  <= err_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_left_pwm      <= wheel(tl, max_pwm);
          out_right_pwm     <= wheel(tr, max_pwm);
          out_heading_error <= err_r;
          out_correction    <= tc;
          out_valid         <= 1'b1;
          state_r           <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/hpd_front.sv */
//------------------------------------------------------------------------------
// hpd_front
// Input front end: takes items and configuration writes, holds the registers.
//------------------------------------------------------------------------------
`default_nettype none
module hpd_front
  import hpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic signed [15:0] in_target_dx,
  input  wire logic signed [15:0] in_target_dy,
  input  wire logic signed [15:0] in_heading_x,
  input  wire logic signed [15:0] in_heading_y,
  input  wire logic signed [15:0] in_heading_angle,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output item_t                   q_item,
  output logic signed [15:0]      kp_r,
  output logic signed [15:0]      kd_r,
  output logic [7:0]              base_r,
  output logic [7:0]              max_r
);

  assign cfg_ready = 1'b1;
  assign q_valid   = in_valid;
  assign in_ready  = q_ready;
  always_comb begin
    q_item.by_angle = in_func;
    q_item.tdx      = in_target_dx;
    q_item.tdy      = in_target_dy;
    q_item.hx       = in_heading_x;
    q_item.hy       = in_heading_y;
    q_item.hang     = in_heading_angle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      kd_r   <= '0;
      base_r <= '0;
      max_r  <= 8'd160;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegKp:   kp_r   <= cfg_data;
        RegKd:   kd_r   <= cfg_data;
        RegBase: base_r <= cfg_data[7:0];
        RegMax:  max_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/heading_pd_differential_drive.sv */
// Sequence: an angle-heading item takes one 16-step CORDIC pass, a vector item
// two, followed by the error, multiply, sum and output states. The back end
// takes its next item only after its result has left, so it never starts a new
// item before the last one is through.
// Reset: synchronous active-low rst_n; gains clear, max_pwm is 160,
// previous error clears.
//------------------------------------------------------------------------------
// heading_pd_differential_drive
// PD heading controller producing wheel PWMs from target and heading.
//------------------------------------------------------------------------------
`default_nettype none
module heading_pd_differential_drive
  import hpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic signed [15:0] in_target_dx,
  input  wire logic signed [15:0] in_target_dy,
  input  wire logic signed [15:0] in_heading_x,
  input  wire logic signed [15:0] in_heading_y,
  input  wire logic signed [15:0] in_heading_angle,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_left_pwm,
  output logic [7:0]              out_right_pwm,
  output logic signed [16:0]      out_heading_error,
  output logic signed [15:0]      out_correction
);

  logic               fq_valid, fq_ready, bq_valid, bq_ready;
  item_t              fq_item, bq_item;
  logic signed [15:0] kp, kd;
  logic [7:0]         base, maxp;

  hpd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_target_dx(in_target_dx), .in_target_dy(in_target_dy),
    .in_heading_x(in_heading_x), .in_heading_y(in_heading_y),
    .in_heading_angle(in_heading_angle),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item),
    .kp_r(kp), .kd_r(kd), .base_r(base), .max_r(maxp)
  );

  hpd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_item),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_item)
  );

  hpd_back u_back (
    .clk(clk), .rst_n(rst_n),
    .item_valid(bq_valid), .item_ready(bq_ready), .item(bq_item),
    .kp(kp), .kd(kd), .base_pwm(base), .max_pwm(maxp),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_left_pwm(out_left_pwm), .out_right_pwm(out_right_pwm),
    .out_heading_error(out_heading_error), .out_correction(out_correction)
  );

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
//------------------------------------------------------------------------------
// tb
// Randomized check of the PD heading controller against a bit-exact predictor.
// Items are streamed with bursty valid and a stalling receiver, gains and wheel
// limits are changed between phases, and every result is compared in order.
//------------------------------------------------------------------------------
`default_nettype none

class pwm_scoreboard;
  logic signed [15:0] kp, kd;
  logic [7:0]         base, maxp;
  logic signed [16:0] prev_err;
  logic [7:0]         q_left[$], q_right[$];
  logic signed [16:0] q_err[$];
  logic signed [15:0] q_corr[$];
  int                 mismatches;
  int                 checked;

  function new();
    kp = 0; kd = 0; base = 0; maxp = 8'd160; prev_err = 0;
    mismatches = 0; checked = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] data);
    case (idx)
      hpd_pkg::RegKp:   kp = data;
      hpd_pkg::RegKd:   kd = data;
      hpd_pkg::RegBase: base = data[7:0];
      default:          maxp = data[7:0];
    endcase
  endfunction

  function longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -64'sd1 - ((-64'sd1 - v) >>> s);
  endfunction

  function longint trunc_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  // CORDIC bearing in Q3.13; the accumulator runs in 2^-16 rad.
  function longint bearing(longint y, longint x);
    longint xs, ys, z, t, dx, dy, q;
    int n;
    xs = x * 65536; ys = y * 65536; z = 0;
    if (x == 0 && y == 0) return 0;
    if (xs < 0) begin
      if (ys >= 0) begin
        t = xs; xs = ys; ys = -t; z = 102944;
      end else begin
        t = xs; xs = -ys; ys = t; z = -102944;
      end
    end
    n = (hpd_pkg::CordicSteps < 24) ? hpd_pkg::CordicSteps : 24;
    for (int i = 0; i < n; i++) begin
      dx = floor_shift(ys, i); dy = floor_shift(xs, i);
      if (ys >= 0) begin
        xs += dx; ys -= dy; z += atan_step(i);
      end else begin
        xs -= dx; ys += dy; z -= atan_step(i);
      end
    end
    q = floor_shift(z + 4, 3);
    if (q > 25736) q = 25736;
    if (q < -25736) q = -25736;
    return q;
  endfunction

  function longint atan_step(int i);
    longint tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 17) ? tab[i] : 0;
  endfunction

  function logic [7:0] wheel(longint sum);
    longint v;
    v = trunc_shift(sum, 21);
    if (v > longint'(maxp)) v = longint'(maxp);
    else if (v < 10) v = 10;
    return v[7:0];
  endfunction

  function void note_input(logic fn, logic signed [15:0] tdx, tdy, hx, hy, hang);
    longint b, h, e, pd, bq, c;
    b = bearing(tdy, tdx);
    h = fn ? longint'(hang) : bearing(hy, hx);
    e = b - h;
    if (e > 25736 || e < -25736) begin
      if (b < 0) b += 51472;
      if (h < 0) h += 51472;
      e = b - h;
    end
    pd = longint'(kp) * e + longint'(kd) * (e - longint'(prev_err));
    prev_err = e;
    bq = longint'(base) <<< 21;
    q_left.push_back(wheel(fn ? bq - pd : bq + pd));
    q_right.push_back(wheel(fn ? bq + pd : bq - pd));
    c = trunc_shift(pd, 21);
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    q_err.push_back(e);
    q_corr.push_back(c);
  endfunction

  function void check_result(logic [7:0] l, r, logic signed [16:0] e,
                             logic signed [15:0] c);
    logic [7:0] el, er;
    logic signed [16:0] ee;
    logic signed [15:0] ec;
    if (q_left.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result l=%0d r=%0d", l, r);
      return;
    end
    el = q_left.pop_front(); er = q_right.pop_front();
    ee = q_err.pop_front(); ec = q_corr.pop_front();
    checked++;
    if (l !== el || r !== er || e !== ee || c !== ec) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch #%0d: exp l=%0d r=%0d err=%0d corr=%0d, %s",
                 checked, el, er, ee, ec,
                 $sformatf("got l=%0d r=%0d err=%0d corr=%0d", l, r, e, c));
    end
  endfunction

  function int pending();
    return q_left.size();
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hpd_pkg::*;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, in_func = 0;
  logic signed [15:0] in_target_dx = 0, in_target_dy = 0, in_heading_x = 0,
                      in_heading_y = 0, in_heading_angle = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic out_valid, out_ready = 0;
  logic [7:0] out_left_pwm, out_right_pwm;
  logic signed [16:0] out_heading_error;
  logic signed [15:0] out_correction;

  pwm_scoreboard board = new();
  int cycles = 0;
  int items_sent = 0;
  int burst_left = 0;

  heading_pd_differential_drive u_dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb failed");
      $finish;
    end
  end

  // Receiver stalls in a pattern of its own; long stretches with no stalls.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (cycles[11:9] == 3'd5) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
    if (rst_n && out_valid && out_ready)
      board.check_result(out_left_pwm, out_right_pwm, out_heading_error,
                         out_correction);
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_reg(idx, data);
  endtask

  task automatic send(logic fn, logic signed [15:0] tdx, tdy, hx, hy, hang);
    int gap;
    // Bursty sender: a random gap opens each new burst.
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 30);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1; in_func <= fn; in_target_dx <= tdx; in_target_dy <= tdy;
    in_heading_x <= hx; in_heading_y <= hy; in_heading_angle <= hang;
    do @(posedge clk); while (!in_ready);
    board.note_input(fn, tdx, tdy, hx, hy, hang);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 0;
      3: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [15:0] vals[6] = '{16'sh8000, 16'sh7fff, 0, 16'sh0001, -16'sd1,
                                    16'sd100};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero vector, negative x axis, axes, extremes, odd angles.
    send(0, 0, 0, 0, 0, 0);
    send(0, -16'sd500, 0, 16'sd500, 0, 0);
    send(0, 16'sd500, 0, -16'sd500, 0, 0);
    send(1, 16'sh8000, 0, 0, 0, 16'sh7fff);
    send(1, 16'sh7fff, 16'sh7fff, 0, 0, 16'sh8000);
    send(0, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 0);
    send(1, -16'sd1, 16'sd1, 16'sh7fff, 16'sh8000, 16'sd25736);
    send(1, 16'sd1, -16'sd1, 0, 0, -16'sd25736);
    drain();

    write_reg(RegKp, 16'sh0100); write_reg(RegKd, 16'sh0080);
    write_reg(RegBase, 16'd100); write_reg(RegMax, 16'd200);
    foreach (vals[i]) send(i % 2, vals[i], vals[(i + 1) % 6], vals[(i + 2) % 6],
                           vals[(i + 3) % 6], vals[(i + 4) % 6]);
    drain();

    // Random phases with fresh settings, extremes included.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin write_reg(RegKp, 16'h7fff); write_reg(RegKd, 16'h8000);
                 write_reg(RegBase, 16'd255); write_reg(RegMax, 16'd255); end
        1: begin write_reg(RegKp, 16'h8000); write_reg(RegKd, 16'h7fff);
                 write_reg(RegBase, 16'd0); write_reg(RegMax, 16'd0); end
        2: begin write_reg(RegMax, 16'd10); write_reg(RegBase, 16'd10); end
        default: begin
          write_reg(RegKp, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2048));
          write_reg(RegKd, $urandom);
          write_reg(RegBase, $urandom_range(0, 255));
          write_reg(RegMax, $urandom_range(0, 255));
        end
      endcase
      repeat (125) send($urandom_range(0, 1), rnd16(), rnd16(), rnd16(), rnd16(),
                        $urandom_range(0, 3) == 0 ? rnd16()
                          : $signed(16'($urandom_range(0, 51472))) - 16'sd25736);
      drain();
    end

    $display("sent %0d items over ten gain settings, %0d results compared",
             items_sent, board.checked);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("tb failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
